// ----- rtl/tdfa_pkg.sv -----
// Shared types and constants for the table-driven automaton acceptor.
package tdfa_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
	localparam int IDX_W         = 6;
	localparam int STATE_W       = 8;
	localparam int SYM_W         = 8;
	localparam int MARK_COUNT    = 1 << STATE_W;

	typedef enum logic [1:0] {
		OP_WRITE_ENTRY = 2'd0,
		OP_WRITE_MARK  = 2'd1,
		OP_FEED        = 2'd2,
		OP_END         = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_WRITTEN   = 3'd0,
		STAT_TAKEN     = 3'd1,
		STAT_NO_TRANS  = 3'd2,
		STAT_ACCEPTED  = 3'd3,
		STAT_NOT_FINAL = 3'd4,
		STAT_IGNORED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_JUDGE
	} fsm_t;

	// Transition table write request
	typedef struct packed {
		logic                 en;
		logic [TBL_IDX_W-1:0] idx;
		logic                 valid;
		logic [STATE_W-1:0]   from;
		logic [SYM_W-1:0]     sym;
		logic [STATE_W-1:0]   dest;
	} tbl_wr_t;

	// Transition table read data (registered)
	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] from;
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] dest;
	} tbl_rd_t;

endpackage

// ----- rtl/tdfa_table.sv -----
// Transition table: entry memory with a registered read port and per-entry valid flops.
module tdfa_table (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tdfa_pkg::tbl_wr_t                     wr,
	input  logic                                  rd_en,
	input  logic [tdfa_pkg::TBL_IDX_W-1:0]        rd_idx,
	output tdfa_pkg::tbl_rd_t                     rd
);
	import tdfa_pkg::*;

	localparam int ENTRY_W = 2 * STATE_W + SYM_W;

	logic [ENTRY_W-1:0]       mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [ENTRY_W-1:0]       rd_data_s1;
	logic                     rd_vld_s1;

	// Valid bits: cleared at reset, written with each entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= wr.valid;
		end
	end

	// Entry payload memory
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= {wr.from, wr.sym, wr.dest};
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
			rd_vld_s1  <= vld_q[rd_idx];
		end
	end

	assign rd.valid = rd_vld_s1;
	assign rd.from  = rd_data_s1[ENTRY_W-1 -: STATE_W];
	assign rd.sym   = rd_data_s1[STATE_W +: SYM_W];
	assign rd.dest  = rd_data_s1[STATE_W-1:0];

endmodule

// ----- rtl/table_driven_dfa_acceptor_top.sv -----
// Top level of the table-driven automaton acceptor.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  item in  | start & !busy        | operation, entry_*, mark_*, symbol_type
//  result   | done (one cycle)     | status, present_state, matched_entry
//  config   | cfg_wr_en            | cfg_wr_data (initial state)
//
// Writes, marks and feeds after a failure: result in the cycle after accept.
// Feed: one table read per cycle from entry 0 up, through the single read port
// of the transition table memory.
// End of sequence: one registered final-mark memory read, judged in the judge state.
// Reset clears the table valid flops and final-mark valid flops at once; no sweep.
// busy is high while a scan or judge is in progress; results cannot be stalled.
module table_driven_dfa_acceptor_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         operation,
	input  logic [tdfa_pkg::IDX_W-1:0]         entry_index,
	input  logic                               entry_valid,
	input  logic [tdfa_pkg::STATE_W-1:0]       entry_from_state,
	input  logic [tdfa_pkg::SYM_W-1:0]         entry_symbol,
	input  logic [tdfa_pkg::STATE_W-1:0]       entry_destination,
	input  logic [tdfa_pkg::STATE_W-1:0]       mark_state,
	input  logic                               mark_final,
	input  logic [tdfa_pkg::SYM_W-1:0]         symbol_type,
	input  logic                               cfg_wr_en,
	input  logic [tdfa_pkg::STATE_W-1:0]       cfg_wr_data,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [tdfa_pkg::STATE_W-1:0]       present_state,
	output logic [tdfa_pkg::IDX_W-1:0]         matched_entry
);
	import tdfa_pkg::*;

	localparam logic [TBL_IDX_W-1:0] LAST_ENTRY = TBL_IDX_W'(TABLE_ENTRIES - 1);

	fsm_t                 fsm_q, fsm_nxt;
	op_t                  op;
	logic                 accept;
	logic [STATE_W-1:0]   init_q, cur_q, eff_state;
	logic                 fresh_q, failed_q, eff_failed;
	logic [SYM_W-1:0]     sym_q;
	logic [TBL_IDX_W-1:0] ent_s1;
	logic                 hit, last;

	tbl_wr_t              tbl_wr;
	tbl_rd_t              tbl_rd;
	logic                 tbl_rd_en;
	logic [TBL_IDX_W-1:0] tbl_rd_idx;

	logic                 fin_mem [MARK_COUNT];
	logic [MARK_COUNT-1:0] fin_vld_q;
	logic                 fin_s1, fin_v_s1;

	logic                 res_fire;
	status_t              res_status;
	logic [STATE_W-1:0]   res_state;
	logic [IDX_W-1:0]     res_match;
	logic                 done_q;
	status_t              status_q;
	logic [STATE_W-1:0]   state_q;
	logic [IDX_W-1:0]     match_q;

	assign busy       = (fsm_q != FSM_IDLE);
	assign accept     = start && !busy;
	assign op         = op_t'(operation);
	assign eff_state  = fresh_q ? init_q : cur_q;
	assign eff_failed = fresh_q ? 1'b0 : failed_q;
	assign hit        = tbl_rd.valid && (tbl_rd.from == cur_q) && (tbl_rd.sym == sym_q);
	assign last       = (ent_s1 == LAST_ENTRY);

	// Table write from an accepted entry item
	always_comb begin
		tbl_wr.en    = accept && (op == OP_WRITE_ENTRY) && (int'(entry_index) < TABLE_ENTRIES);
		tbl_wr.idx   = TBL_IDX_W'(entry_index);
		tbl_wr.valid = entry_valid;
		tbl_wr.from  = entry_from_state;
		tbl_wr.sym   = entry_symbol;
		tbl_wr.dest  = entry_destination;
	end

	tdfa_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.rd_en  (tbl_rd_en),
		.rd_idx (tbl_rd_idx),
		.rd     (tbl_rd)
	);

	// Next state
	always_comb begin
		fsm_nxt = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept && op == OP_FEED && !eff_failed) begin
					fsm_nxt = FSM_SCAN;
				end else if (accept && op == OP_END) begin
					fsm_nxt = FSM_JUDGE;
				end
			end
			FSM_SCAN: begin
				if (hit || last) begin
					fsm_nxt = FSM_IDLE;
				end
			end
			FSM_JUDGE: fsm_nxt = FSM_IDLE;
			default:   fsm_nxt = FSM_IDLE;
		endcase
	end

	// Outputs: table reads and result
	always_comb begin
		tbl_rd_en  = 1'b0;
		tbl_rd_idx = '0;
		res_fire   = 1'b0;
		res_status = STAT_WRITTEN;
		res_state  = cur_q;
		res_match  = '0;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_WRITE_ENTRY, OP_WRITE_MARK: begin
							res_fire  = 1'b1;
							res_state = eff_state;
						end
						OP_FEED: begin
							if (eff_failed) begin
								res_fire   = 1'b1;
								res_status = STAT_IGNORED;
							end else begin
								tbl_rd_en = 1'b1;
							end
						end
						OP_END: ;
						default: ;
					endcase
				end
			end
			FSM_SCAN: begin
				if (hit) begin
					res_fire   = 1'b1;
					res_status = STAT_TAKEN;
					res_state  = tbl_rd.dest;
					res_match  = IDX_W'(ent_s1);
				end else if (last) begin
					res_fire   = 1'b1;
					res_status = STAT_NO_TRANS;
				end else begin
					tbl_rd_en  = 1'b1;
					tbl_rd_idx = TBL_IDX_W'(ent_s1 + 1'b1);
				end
			end
			FSM_JUDGE: begin
				res_fire = 1'b1;
				priority if (failed_q) begin
					res_status = STAT_NO_TRANS;
				end else if (fin_s1 && fin_v_s1) begin
					res_status = STAT_ACCEPTED;
				end else begin
					res_status = STAT_NOT_FINAL;
				end
			end
			default: ;
		endcase
	end

	// Control registers: sequencer, configuration, sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= FSM_IDLE;
			init_q   <= '0;
			cur_q    <= '0;
			fresh_q  <= 1'b1;
			failed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			fsm_q  <= fsm_nxt;
			done_q <= res_fire;
			if (cfg_wr_en) begin
				init_q <= cfg_wr_data;
			end
			unique case (fsm_q)
				FSM_IDLE: begin
					if (accept && (op == OP_FEED || op == OP_END) && fresh_q) begin
						cur_q    <= init_q;
						fresh_q  <= 1'b0;
						failed_q <= 1'b0;
					end
				end
				FSM_SCAN: begin
					if (hit) begin
						cur_q <= tbl_rd.dest;
					end else if (last) begin
						failed_q <= 1'b1;
					end
				end
				FSM_JUDGE: begin
					fresh_q  <= 1'b1;
					failed_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Scan payload: symbol and entry index in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= symbol_type;
		end
		if (tbl_rd_en) begin
			ent_s1 <= tbl_rd_idx;
		end
	end

	// Final-mark valid flops, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q <= '0;
		end else if (accept && op == OP_WRITE_MARK) begin
			fin_vld_q[mark_state] <= 1'b1;
		end
	end

	// Final-mark memory: write on mark item, read on end item
	always_ff @(posedge clk) begin
		if (accept && op == OP_WRITE_MARK) begin
			fin_mem[mark_state] <= mark_final;
		end
		if (accept && op == OP_END) begin
			fin_s1   <= fin_mem[eff_state];
			fin_v_s1 <= fin_vld_q[eff_state];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q <= res_status;
			state_q  <= res_state;
			match_q  <= res_match;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign present_state = state_q;
	assign matched_entry = match_q;

	// Every accepted item either reports next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted item neither reported nor in progress");

	// Leaving a scan or judge always delivers a result
	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// Only a taken symbol reports a nonzero matched entry
	a_match_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_TAKEN) |-> (matched_entry == '0))
		else $error("matched_entry set on a result other than symbol taken");

	// A scan never runs while the table is being written
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == FSM_SCAN) |-> !tbl_wr.en)
		else $error("table write during scan");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the table-driven automaton acceptor: directed and random items.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tdfa_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int MAX_GAP       = 11;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_STATES  = 6;
	localparam int PHASE_SYMBOLS = 4;
	localparam int PHASE_ARCS    = 24;
	localparam int PHASE_BODY    = 120;

	typedef struct {
		op_t                op;
		bit [IDX_W-1:0]     idx;
		bit                 valid;
		bit [STATE_W-1:0]   from;
		bit [SYM_W-1:0]     sym;
		bit [STATE_W-1:0]   dest;
		bit [STATE_W-1:0]   mark_st;
		bit                 mark_on;
		bit [SYM_W-1:0]     symbol;
	} item_t;

	typedef struct {
		status_t            status;
		bit [STATE_W-1:0]   state;
		bit [IDX_W-1:0]     entry;
	} outcome_t;

	typedef struct {
		bit                 valid;
		bit [STATE_W-1:0]   from;
		bit [SYM_W-1:0]     sym;
		bit [STATE_W-1:0]   dest;
	} arc_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [IDX_W-1:0]   entry_index;
	logic               entry_valid;
	logic [STATE_W-1:0] entry_from_state;
	logic [SYM_W-1:0]   entry_symbol;
	logic [STATE_W-1:0] entry_destination;
	logic [STATE_W-1:0] mark_state;
	logic               mark_final;
	logic [SYM_W-1:0]   symbol_type;
	logic               cfg_wr_en;
	logic [STATE_W-1:0] cfg_wr_data;
	logic               done;
	logic [2:0]         status;
	logic [STATE_W-1:0] present_state;
	logic [IDX_W-1:0]   matched_entry;

	// Shadow copy of the automaton
	arc_t               arcs [TABLE_ENTRIES];
	bit                 accepting [MARK_COUNT];
	bit [STATE_W-1:0]   cur_state;
	bit [STATE_W-1:0]   init_shadow;
	bit                 seq_fresh;
	bit                 seq_failed;

	outcome_t           pending_outcomes [$];
	int                 fail_count  = 0;
	int                 cycle_count = 0;
	bit                 gaps_on     = 1'b1;

	table_driven_dfa_acceptor_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.entry_index       (entry_index),
		.entry_valid       (entry_valid),
		.entry_from_state  (entry_from_state),
		.entry_symbol      (entry_symbol),
		.entry_destination (entry_destination),
		.mark_state        (mark_state),
		.mark_final        (mark_final),
		.symbol_type       (symbol_type),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.done              (done),
		.status            (status),
		.present_state     (present_state),
		.matched_entry     (matched_entry)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("table_driven_dfa_acceptor_top regression: fail");
			$finish;
		end
	end

	// Drop the shadow automaton to its post-reset contents
	function automatic void clear_automaton();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			arcs[i] = '{valid: 1'b0, from: '0, sym: '0, dest: '0};
		for (int i = 0; i < MARK_COUNT; i++)
			accepting[i] = 1'b0;
		cur_state   = '0;
		init_shadow = '0;
		seq_fresh   = 1'b1;
		seq_failed  = 1'b0;
	endfunction

	// Apply one item to the shadow automaton and return the result it must give
	function automatic outcome_t advance_automaton(item_t it);
		outcome_t o;
		int       hit;
		hit      = -1;
		o.status = STAT_WRITTEN;
		o.state  = seq_fresh ? init_shadow : cur_state;
		o.entry  = '0;
		case (it.op)
			OP_WRITE_ENTRY: begin
				arcs[it.idx] = '{valid: it.valid, from: it.from, sym: it.sym, dest: it.dest};
			end
			OP_WRITE_MARK: begin
				accepting[it.mark_st] = it.mark_on;
			end
			default: begin
				// A new sequence loads the initial state on its first feed or end
				if (seq_fresh) begin
					cur_state  = init_shadow;
					seq_fresh  = 1'b0;
					seq_failed = 1'b0;
				end
				o.state = cur_state;
				if (it.op == OP_FEED) begin
					if (seq_failed) begin
						o.status = STAT_IGNORED;
					end else begin
						// Lowest-indexed valid matching entry wins
						for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
							if (arcs[i].valid && arcs[i].from == cur_state &&
							    arcs[i].sym == it.symbol)
								hit = i;
						if (hit >= 0) begin
							cur_state = arcs[hit].dest;
							o.status  = STAT_TAKEN;
							o.state   = cur_state;
							o.entry   = IDX_W'(hit);
						end else begin
							seq_failed = 1'b1;
							o.status   = STAT_NO_TRANS;
						end
					end
				end else begin
					if (seq_failed)
						o.status = STAT_NO_TRANS;
					else if (accepting[cur_state])
						o.status = STAT_ACCEPTED;
					else
						o.status = STAT_NOT_FINAL;
					seq_fresh  = 1'b1;
					seq_failed = 1'b0;
				end
			end
		endcase
		return o;
	endfunction

	// Item builders: fields the operation does not use carry random values
	function automatic item_t noise_item(op_t op);
		item_t it;
		it.op      = op;
		it.idx     = IDX_W'($urandom);
		it.valid   = 1'($urandom);
		it.from    = STATE_W'($urandom);
		it.sym     = SYM_W'($urandom);
		it.dest    = STATE_W'($urandom);
		it.mark_st = STATE_W'($urandom);
		it.mark_on = 1'($urandom);
		it.symbol  = SYM_W'($urandom);
		return it;
	endfunction

	function automatic item_t entry_item(bit [IDX_W-1:0] idx, bit valid,
			bit [STATE_W-1:0] from, bit [SYM_W-1:0] sym, bit [STATE_W-1:0] dest);
		item_t it;
		it       = noise_item(OP_WRITE_ENTRY);
		it.idx   = idx;
		it.valid = valid;
		it.from  = from;
		it.sym   = sym;
		it.dest  = dest;
		return it;
	endfunction

	function automatic item_t mark_item(bit [STATE_W-1:0] st, bit on);
		item_t it;
		it         = noise_item(OP_WRITE_MARK);
		it.mark_st = st;
		it.mark_on = on;
		return it;
	endfunction

	function automatic item_t feed_item(bit [SYM_W-1:0] sym);
		item_t it;
		it        = noise_item(OP_FEED);
		it.symbol = sym;
		return it;
	endfunction

	// Send one item, wait for its acceptance and queue its predicted result
	task automatic send_item(item_t it);
		int   gap;
		logic held;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start             <= 1'b1;
		operation         <= it.op;
		entry_index       <= it.idx;
		entry_valid       <= it.valid;
		entry_from_state  <= it.from;
		entry_symbol      <= it.sym;
		entry_destination <= it.dest;
		mark_state        <= it.mark_st;
		mark_final        <= it.mark_on;
		symbol_type       <= it.symbol;
		// busy changes only at the rising edge, so sample it mid-cycle
		do begin
			@(negedge clk);
			held = busy;
			@(posedge clk);
		end while (held !== 1'b0);
		pending_outcomes = {pending_outcomes, advance_automaton(it)};
	endtask

	// Hold off until every result has come back, then let the block settle
	task automatic quiesce();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_initial_state(bit [STATE_W-1:0] value);
		quiesce();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		init_shadow = value;
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (done !== 1'b1) begin
				$error("done: expected 0 or 1, actual %b", done);
				fail_count++;
			end else if (pending_outcomes.size() == 0) begin
				$error("result with none pending: status %0d present_state %0d matched_entry %0d",
					status, present_state, matched_entry);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (present_state !== want.state) begin
					$error("present_state: expected %0d, actual %0d", want.state, present_state);
					fail_count++;
				end
				if (matched_entry !== want.entry) begin
					$error("matched_entry: expected %0d, actual %0d", want.entry, matched_entry);
					fail_count++;
				end
			end
		end
	end

	// Empty table after reset: empty sequence, failure, ignored symbols
	task automatic test_empty_automaton();
		send_item(noise_item(OP_END));
		send_item(feed_item(8'h00));
		send_item(feed_item(8'hFF));
		send_item(noise_item(OP_END));
		send_item(mark_item(8'h00, 1'b1));
		send_item(noise_item(OP_END));
		send_item(mark_item(8'h00, 1'b0));
	endtask

	// Invalid entries are skipped and the lowest matching index wins
	task automatic test_entry_priority();
		send_item(entry_item(6'd63, 1'b1, 8'h00, 8'hFF, 8'hFF));
		send_item(entry_item(6'd0, 1'b0, 8'h00, 8'hFF, 8'h01));
		send_item(feed_item(8'hFF));
		send_item(mark_item(8'hFF, 1'b1));
		send_item(noise_item(OP_END));
		send_item(entry_item(6'd5, 1'b1, 8'h00, 8'hFF, 8'h5A));
		send_item(feed_item(8'hFF));
		send_item(noise_item(OP_END));
		send_item(entry_item(6'd0, 1'b1, 8'h00, 8'hFF, 8'h00));
		send_item(feed_item(8'hFF));
		send_item(feed_item(8'hFF));
		send_item(noise_item(OP_END));
	endtask

	// Initial state register: fresh reports, mid-sequence change, failure path
	task automatic test_initial_state_register();
		write_initial_state(8'hFF);
		send_item(entry_item(6'd1, 1'b1, 8'hFF, 8'h00, 8'h00));
		send_item(feed_item(8'h00));
		write_initial_state(8'h3C);
		send_item(noise_item(OP_END));
		send_item(noise_item(OP_END));
		send_item(feed_item(8'h11));
		send_item(feed_item(8'h00));
		send_item(entry_item(6'd2, 1'b1, 8'h3C, 8'h11, 8'hC3));
		send_item(noise_item(OP_END));
	endtask

	// Phases of small random automata walked mostly by symbols they know
	task automatic test_random_sequences();
		bit [STATE_W-1:0] phase_states [PHASE_STATES];
		bit [SYM_W-1:0]   phase_syms [PHASE_SYMBOLS];
		int               sent;
		int               roll;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_STATES; k++)
				phase_states[k] = STATE_W'($urandom);
			for (int k = 0; k < PHASE_SYMBOLS; k++)
				phase_syms[k] = SYM_W'($urandom);
			case ($urandom_range(0, 3))
				0: phase_states[0] = '0;
				1: phase_states[0] = '1;
				default: ;
			endcase
			write_initial_state(phase_states[0]);
			// Load the automaton
			for (int k = 0; k < PHASE_ARCS; k++) begin
				send_item(entry_item(IDX_W'($urandom), $urandom_range(0, 7) != 0,
					phase_states[$urandom_range(0, PHASE_STATES-1)],
					phase_syms[$urandom_range(0, PHASE_SYMBOLS-1)],
					phase_states[$urandom_range(0, PHASE_STATES-1)]));
				sent++;
			end
			for (int k = 0; k < PHASE_STATES; k++) begin
				send_item(mark_item(phase_states[k], 1'($urandom)));
				sent++;
			end
			// Run sequences, with some rewrites and noise mixed in
			for (int k = 0; k < PHASE_BODY; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					send_item(feed_item(phase_syms[$urandom_range(0, PHASE_SYMBOLS-1)]));
				else if (roll < 82)
					send_item(noise_item(OP_END));
				else if (roll < 88)
					send_item(feed_item(SYM_W'($urandom)));
				else if (roll < 93)
					send_item(entry_item(IDX_W'($urandom), 1'($urandom),
						phase_states[$urandom_range(0, PHASE_STATES-1)],
						phase_syms[$urandom_range(0, PHASE_SYMBOLS-1)],
						phase_states[$urandom_range(0, PHASE_STATES-1)]));
				else if (roll < 96)
					send_item(mark_item(phase_states[$urandom_range(0, PHASE_STATES-1)],
						1'($urandom)));
				else
					send_item(noise_item(op_t'($urandom_range(0, 3))));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		start             <= 1'b0;
		operation         <= OP_WRITE_ENTRY;
		entry_index       <= '0;
		entry_valid       <= 1'b0;
		entry_from_state  <= '0;
		entry_symbol      <= '0;
		entry_destination <= '0;
		mark_state        <= '0;
		mark_final        <= 1'b0;
		symbol_type       <= '0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		clear_automaton();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_automaton();
		test_entry_priority();
		test_initial_state_register();
		test_random_sequences();
		quiesce();

		if (fail_count == 0)
			$display("table_driven_dfa_acceptor_top regression: pass");
		else
			$display("table_driven_dfa_acceptor_top regression: fail");
		$finish;
	end

endmodule
